// ----- src/bal_pkg.sv -----
// Package for the bounded array list: widths, request codes, state encoding.
`default_nettype none

package bal_pkg;

    // Default list capacity
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int REQ_W  = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;

    // Value returned by a refused get
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_GET   = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_FILL  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

endpackage

`default_nettype wire

// ----- src/bal_if.sv -----
// Request and response channel interfaces of the bounded array list.
`default_nettype none

interface bal_req_if
    import bal_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output pos, output value, input ready);
    modport sink   (input valid, input req_type, input pos, input value, output ready);
endinterface

interface bal_rsp_if
    import bal_pkg::*;
#(
    parameter int LEN_W = 5
) ();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         list_length;

    modport source (output valid, output ok, output read_value, output list_length,
                    input ready);
    modport sink   (input valid, input ok, input read_value, input list_length,
                    output ready);
endinterface

`default_nettype wire

// ----- src/bounded_array_list.sv -----
// Bounded array list top level: entry memory, length register and shift sequencer.
// From request accept to response valid: a get passes ST_GET for the registered
// read; set, append, refused requests and insert at the end go straight to ST_RESP;
// a shifting insert passes ST_SHIFT and ST_FILL, a shifting delete ST_SHIFT, before
// ST_RESP. Throughput: one request at a time; the shift loop moves one entry per
// cycle over the memory port. Reset clears the length to zero; memory is not cleared.
`default_nettype none

module bounded_array_list
    import bal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
    input  wire     clk,
    input  wire     rst_n,
    bal_req_if.sink req,
    bal_rsp_if.source rsp
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    // Entry memory
    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rdata_reg;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic                     mem_re;
    logic [IDX_W-1:0]         mem_raddr;

    // Control and payload registers
    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [IDX_W-1:0]         cur_reg, cur_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic                     ins_reg, ins_next;
    logic                     res_ok_reg, res_ok_next;
    logic signed [DATA_W-1:0] res_rd_reg, res_rd_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_ok_reg, out_ok_next;
    logic signed [DATA_W-1:0] out_rd_reg, out_rd_next;
    logic [LEN_W-1:0]         out_len_reg, out_len_next;

    // Request decode helpers
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;
    logic             in_range;
    logic             ins_range;
    logic             not_full;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] len_idx;
    logic [IDX_W-1:0] last_idx;

    assign pos_ext   = CMP_W'(req.pos);
    assign len_ext   = CMP_W'(len_reg);
    assign in_range  = pos_ext < len_ext;
    assign ins_range = pos_ext <= len_ext;
    assign not_full  = len_reg < LEN_W'(CAPACITY);
    assign pos_idx   = pos_ext[IDX_W-1:0];
    assign len_idx   = IDX_W'(len_reg);
    assign last_idx  = IDX_W'(len_reg - LEN_W'(1));

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.read_value  = out_rd_reg;
    assign rsp.list_length = out_len_reg;

    // Sequence requests and drive the memory port
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        val_next       = val_reg;
        ins_next       = ins_reg;
        res_ok_next    = res_ok_reg;
        res_rd_next    = res_rd_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_rd_next    = out_rd_reg;
        out_len_next   = out_len_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_wdata      = rdata_reg;
        mem_re         = 1'b0;
        mem_raddr      = cur_reg;

        // Drop the response once the sink takes it
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    pos_next    = pos_idx;
                    val_next    = req.value;
                    res_ok_next = 1'b0;
                    res_rd_next = '0;
                    state_next  = ST_RESP;
                    unique case (req.req_type)
                        REQ_GET:
                        begin
                            if (in_range)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_idx;
                                state_next = ST_GET;
                            end
                            else
                            begin
                                res_rd_next = INT_MIN;
                            end
                        end
                        REQ_SET:
                        begin
                            if (in_range)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = pos_idx;
                                mem_wdata   = req.value;
                                res_ok_next = 1'b1;
                            end
                        end
                        REQ_APPEND:
                        begin
                            if (not_full)
                            begin
                                mem_we      = 1'b1;
                                mem_waddr   = len_idx;
                                mem_wdata   = req.value;
                                len_next    = len_reg + LEN_W'(1);
                                res_ok_next = 1'b1;
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (not_full && ins_range)
                            begin
                                if (pos_ext == len_ext)
                                begin
                                    // Insert at the end: no shift
                                    mem_we      = 1'b1;
                                    mem_waddr   = pos_idx;
                                    mem_wdata   = req.value;
                                    len_next    = len_reg + LEN_W'(1);
                                    res_ok_next = 1'b1;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = last_idx;
                                    cur_next   = len_idx;
                                    ins_next   = 1'b1;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (in_range)
                            begin
                                if (pos_idx == last_idx)
                                begin
                                    // Delete the last entry: no shift
                                    len_next    = len_reg - LEN_W'(1);
                                    res_ok_next = 1'b1;
                                end
                                else
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = pos_idx + IDX_W'(1);
                                    cur_next   = pos_idx;
                                    ins_next   = 1'b0;
                                    state_next = ST_SHIFT;
                                end
                            end
                        end
                        default:
                        begin
                            res_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_GET:
            begin
                res_ok_next = 1'b1;
                res_rd_next = rdata_reg;
                state_next  = ST_RESP;
            end

            ST_SHIFT:
            begin
                // Move one entry per cycle, reading the next source ahead
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                mem_wdata = rdata_reg;
                if (ins_reg)
                begin
                    if (cur_reg - IDX_W'(1) == pos_reg)
                    begin
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = cur_reg - IDX_W'(2);
                        cur_next  = cur_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    if (cur_reg + IDX_W'(1) == last_idx)
                    begin
                        len_next    = len_reg - LEN_W'(1);
                        res_ok_next = 1'b1;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = cur_reg + IDX_W'(2);
                        cur_next  = cur_reg + IDX_W'(1);
                    end
                end
            end

            ST_FILL:
            begin
                mem_we      = 1'b1;
                mem_waddr   = pos_reg;
                mem_wdata   = val_reg;
                len_next    = len_reg + LEN_W'(1);
                res_ok_next = 1'b1;
                state_next  = ST_RESP;
            end

            ST_RESP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_rd_next    = res_rd_reg;
                    out_len_next   = len_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        cur_reg     <= cur_next;
        val_reg     <= val_next;
        ins_reg     <= ins_next;
        res_ok_reg  <= res_ok_next;
        res_rd_reg  <= res_rd_next;
        out_ok_reg  <= out_ok_next;
        out_rd_reg  <= out_rd_next;
        out_len_reg <= out_len_next;
    end

endmodule

`default_nettype wire

// ----- src/bal_checker.sv -----
// Port-level assertions for the bounded array list, bound to the top level.
`default_nettype none

module bal_checker
    import bal_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
    input wire                     clk,
    input wire                     rst_n,
    input wire                     req_valid,
    input wire                     req_ready,
    input wire                     rsp_valid,
    input wire                     rsp_ready,
    input wire                     rsp_ok,
    input wire signed [DATA_W-1:0] rsp_read_value,
    input wire [LEN_W-1:0]         rsp_list_length
);

    // Length never exceeds the capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_list_length <= LEN_W'(CAPACITY)))
        else $error("list_length above capacity");

    // A refused request reads back zero or the most negative value
    a_refused_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ok) |-> (rsp_read_value == '0 || rsp_read_value == INT_MIN))
        else $error("refused request with unexpected read_value");

    // One request at a time: ready drops after a transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while busy");

    // A stalled response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_ok) && $stable(rsp_read_value)
             && $stable(rsp_list_length)))
        else $error("stalled response changed");

endmodule

bind bounded_array_list bal_checker #(
    .CAPACITY (CAPACITY),
    .LEN_W    (LEN_W)
) u_bal_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_ok          (rsp.ok),
    .rsp_read_value  (rsp.read_value),
    .rsp_list_length (rsp.list_length)
);

`default_nettype wire
